/* hw/rtl/scaled_glyph_text_renderer_defines.svh */
// Assertion macros shared by the renderer RTL.
// Under synthesis the macros expand to nothing.
`ifndef SCALED_GLYPH_TEXT_RENDERER_DEFINES_SVH
`define SCALED_GLYPH_TEXT_RENDERER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks an implication on every clock edge outside reset.
`define SGTR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition is followed in the next cycle by a result.
`define SGTR_ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`else

`define SGTR_ASSERT(label, clk, rst, prop, msg)
`define SGTR_ASSERT_NEXT(label, clk, rst, cond, nxt, msg)

`endif

`endif

/* hw/rtl/sgtr_pkg.sv */
package sgtr_pkg;

  // Default panel geometry and magnification limit.
  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;
  localparam int DEF_MAX_SCALE    = 8;

  // Field widths of the request and result transactions.
  localparam int REQ_W       = 2;
  localparam int CODE_W      = 8;
  localparam int OX_W        = 7;
  localparam int OY_W        = 6;
  localparam int SCALE_W     = 4;
  localparam int BIDX_W      = 10;
  localparam int STATUS_W    = 3;
  localparam int DATA_W      = 8;

  // Cursor registers are 8 bits; sums of cursor and cell size need 10.
  localparam int CUR_W       = 8;
  localparam int SUM_W       = 10;
  localparam int X_W         = 9;
  localparam logic [SUM_W-1:0] CUR_MAX = SUM_W'(255);

  // Font geometry: 5x7 glyphs in a 6x8 cell.
  localparam int GLYPH_W     = 5;
  localparam int GLYPH_H     = 7;
  localparam int CELL_W      = 6;
  localparam int CELL_H      = 8;
  localparam int GLYPH_IDX_W = 7;
  localparam int GCOL_W      = 3;

  // Character codes.
  localparam logic [CODE_W-1:0] NEWLINE_CODE  = 8'd10;
  localparam logic [CODE_W-1:0] FIRST_PRINT   = 8'd32;
  localparam logic [CODE_W-1:0] LAST_PRINT    = 8'd127;
  localparam logic [CODE_W-1:0] FALLBACK_CODE = 8'd63;

  // Request types.
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DRAWN   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEWLINE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  // Saturate a cursor sum to the 8-bit cursor range.
  function automatic logic [CUR_W-1:0] sat8(input logic [SUM_W-1:0] v);
    logic [CUR_W-1:0] r;
    r = (v > CUR_MAX) ? CUR_MAX[CUR_W-1:0] : v[CUR_W-1:0];
    return r;
  endfunction

  // Map a character byte to a row of the font; unprintable codes show '?'.
  function automatic logic [GLYPH_IDX_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] c;
    c = (code < FIRST_PRINT || code > LAST_PRINT) ? FALLBACK_CODE : code;
    return GLYPH_IDX_W'(c - FIRST_PRINT);
  endfunction

  // Font table: five column bytes per glyph, leftmost column in the top byte.
  function automatic logic [8*GLYPH_W-1:0] glyph_word(input logic [GLYPH_IDX_W-1:0] idx);
    logic [8*GLYPH_W-1:0] w;
    case (idx)
      7'd0:  w = 40'h0000000000;  7'd1:  w = 40'h00005F0000;
      7'd2:  w = 40'h0007000700;  7'd3:  w = 40'h147F147F14;
      7'd4:  w = 40'h242A7F2A12;  7'd5:  w = 40'h2313086462;
      7'd6:  w = 40'h3649552250;  7'd7:  w = 40'h0005030000;
      7'd8:  w = 40'h001C224100;  7'd9:  w = 40'h0041221C00;
      7'd10: w = 40'h14083E0814;  7'd11: w = 40'h08083E0808;
      7'd12: w = 40'h0050300000;  7'd13: w = 40'h0808080808;
      7'd14: w = 40'h0060600000;  7'd15: w = 40'h2010080402;
      7'd16: w = 40'h3E5149453E;  7'd17: w = 40'h00427F4000;
      7'd18: w = 40'h4261514946;  7'd19: w = 40'h2141454B31;
      7'd20: w = 40'h1814127F10;  7'd21: w = 40'h2745454539;
      7'd22: w = 40'h3C4A494930;  7'd23: w = 40'h0171090503;
      7'd24: w = 40'h3649494936;  7'd25: w = 40'h064949291E;
      7'd26: w = 40'h0036360000;  7'd27: w = 40'h0056360000;
      7'd28: w = 40'h0814224100;  7'd29: w = 40'h1414141414;
      7'd30: w = 40'h0041221408;  7'd31: w = 40'h0201510906;
      7'd32: w = 40'h324979413E;  7'd33: w = 40'h7E1111117E;
      7'd34: w = 40'h7F49494936;  7'd35: w = 40'h3E41414122;
      7'd36: w = 40'h7F4141221C;  7'd37: w = 40'h7F49494941;
      7'd38: w = 40'h7F09090901;  7'd39: w = 40'h3E4149497A;
      7'd40: w = 40'h7F0808087F;  7'd41: w = 40'h00417F4100;
      7'd42: w = 40'h2040413F01;  7'd43: w = 40'h7F08142241;
      7'd44: w = 40'h7F40404040;  7'd45: w = 40'h7F020C027F;
      7'd46: w = 40'h7F0408107F;  7'd47: w = 40'h3E4141413E;
      7'd48: w = 40'h7F09090906;  7'd49: w = 40'h3E4151215E;
      7'd50: w = 40'h7F09192946;  7'd51: w = 40'h4649494931;
      7'd52: w = 40'h01017F0101;  7'd53: w = 40'h3F4040403F;
      7'd54: w = 40'h1F2040201F;  7'd55: w = 40'h3F4038403F;
      7'd56: w = 40'h6314081463;  7'd57: w = 40'h0708700807;
      7'd58: w = 40'h6151494543;  7'd59: w = 40'h007F414100;
      7'd60: w = 40'h0204081020;  7'd61: w = 40'h0041417F00;
      7'd62: w = 40'h0402010204;  7'd63: w = 40'h4040404040;
      7'd64: w = 40'h0001020400;  7'd65: w = 40'h2054545478;
      7'd66: w = 40'h7F48444438;  7'd67: w = 40'h3844444420;
      7'd68: w = 40'h384444487F;  7'd69: w = 40'h3854545418;
      7'd70: w = 40'h087E090102;  7'd71: w = 40'h0C5252523E;
      7'd72: w = 40'h7F08040478;  7'd73: w = 40'h00447D4000;
      7'd74: w = 40'h2040443D00;  7'd75: w = 40'h7F10284400;
      7'd76: w = 40'h00417F4000;  7'd77: w = 40'h7C04180478;
      7'd78: w = 40'h7C08040478;  7'd79: w = 40'h3844444438;
      7'd80: w = 40'h7C14141408;  7'd81: w = 40'h081414187C;
      7'd82: w = 40'h7C08040408;  7'd83: w = 40'h4854545420;
      7'd84: w = 40'h043F444020;  7'd85: w = 40'h3C4040207C;
      7'd86: w = 40'h1C2040201C;  7'd87: w = 40'h3C4030403C;
      7'd88: w = 40'h4428102844;  7'd89: w = 40'h0C5050503C;
      7'd90: w = 40'h4464544C44;  7'd91: w = 40'h0008364100;
      7'd92: w = 40'h00007F0000;  7'd93: w = 40'h0041360800;
      7'd94: w = 40'h0804081008;  7'd95: w = 40'h0000000000;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Pick one 7-pixel column out of a font word.
  function automatic logic [GLYPH_H-1:0] glyph_column(input logic [8*GLYPH_W-1:0] w,
                                                      input logic [GCOL_W-1:0] c);
    logic [GLYPH_H-1:0] r;
    case (c)
      3'd0:    r = w[38:32];
      3'd1:    r = w[30:24];
      3'd2:    r = w[22:16];
      3'd3:    r = w[14:8];
      3'd4:    r = w[6:0];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/scaled_glyph_text_renderer.sv */
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   req_type, char_code, first, origin_x,
//                                            origin_y, scale, byte_index
// result    out        out_valid / out_ready status, read_data
//
// A read passes S_READ and an undrawn character S_DECIDE on the way to S_DONE; a clear
// sweeps all PANEL_WIDTH*PAGE_COUNT bytes; a drawn glyph loads its five columns in turn
// and, once per scale step, walks each 8-row page the glyph spans, one frame-store
// read-modify-write per cycle. After reset a clearing pass over PANEL_WIDTH*PAGE_COUNT
// bytes runs before the first request is taken. A stalled result holds the block in its
// final step; a new request is taken while the previous result waits.
`include "scaled_glyph_text_renderer_defines.svh"

module scaled_glyph_text_renderer
  import sgtr_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
  parameter int MAX_SCALE    = DEF_MAX_SCALE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [CODE_W-1:0]   char_code,
  input  logic                first,
  input  logic [OX_W-1:0]     origin_x,
  input  logic [OY_W-1:0]     origin_y,
  input  logic [SCALE_W-1:0]  scale,
  input  logic [BIDX_W-1:0]   byte_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [DATA_W-1:0]   read_data
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int EXP_W       = GLYPH_H * MAX_SCALE;
  localparam int EXT_W       = EXP_W + 16;
  localparam int OFF_W       = $clog2(EXT_W);
  localparam int SX_W        = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int CMP_W       = ((ADDR_W > BIDX_W) ? ADDR_W : BIDX_W) + 1;

  typedef enum logic [6:0] {
    S_WIPE   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_LOAD   = 7'b0010000,
    S_DRAW   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;

  // Clearing sweep.
  logic [ADDR_W-1:0] wipe_addr;
  logic              clr_result;

  // Text cursor.
  logic [CUR_W-1:0]   cursor_col;
  logic [CUR_W-1:0]   cursor_row;
  logic [OX_W-1:0]    line_origin;
  logic [SCALE_W-1:0] cell_scale;
  logic               string_stopped;

  // Latched request and pending result.
  logic                   is_nl;
  logic [GLYPH_IDX_W-1:0] glyph_idx;
  logic                   rd_ok;
  logic [STATUS_W-1:0]    res_status;
  logic [DATA_W-1:0]      res_data;

  // Glyph walk.
  logic [X_W-1:0]    x_cur;
  logic [CUR_W-1:0]  draw_y;
  logic [PAGE_W-1:0] page;
  logic [PAGE_W-1:0] page_first;
  logic [PAGE_W-1:0] page_last;
  logic [GCOL_W-1:0] gcol;
  logic [SX_W-1:0]   sx;
  logic [EXP_W-1:0]  exp_bits;
  logic [EXP_W-1:0]  exp_mask;
  logic [EXP_W-1:0]  exp_next;
  logic [EXP_W-1:0]  mask_next;
  logic [GLYPH_H-1:0] col_bits;

  // Write-back stage of the read-modify-write.
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_bits;
  logic [DATA_W-1:0] wr_mask;

  // Frame store.
  logic [DATA_W-1:0] frame_mem [STORE_BYTES];
  logic [DATA_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // Decision logic.
  logic [SUM_W-1:0]   s_ext;
  logic [SUM_W-1:0]   step_w;
  logic [SUM_W-1:0]   step_h;
  logic [SUM_W-1:0]   glyph_hgt;
  logic               wrap;
  logic [CUR_W-1:0]   row_nl;
  logic [CUR_W-1:0]   col2;
  logic [CUR_W-1:0]   row2;
  logic               bottom;
  logic [CUR_W-1:0]   col_adv;
  logic [SUM_W-1:0]   last_row;
  logic [SCALE_W-1:0] scale_in;

  // Draw address and byte selection.
  logic              x_ok;
  logic [ADDR_W-1:0] draw_addr;
  logic [OFF_W-1:0]  off;
  logic [EXT_W-1:0]  ext_bits;
  logic [EXT_W-1:0]  ext_mask;
  logic [DATA_W-1:0] byte_bits;
  logic [DATA_W-1:0] byte_mask;
  logic              last_page;
  logic              last_sub;
  logic              last_col;
  logic              out_free;
  logic              in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Scale of a new string: zero counts as one, large values saturate.
  always_comb begin
    if (scale == '0) begin
      scale_in = SCALE_W'(1);
    end else if (scale > SCALE_W'(MAX_SCALE)) begin
      scale_in = SCALE_W'(MAX_SCALE);
    end else begin
      scale_in = scale;
    end
  end

  // Cursor arithmetic for the character under decision.
  assign s_ext     = SUM_W'(cell_scale);
  assign step_w    = s_ext * SUM_W'(CELL_W);
  assign step_h    = s_ext * SUM_W'(CELL_H);
  assign glyph_hgt = s_ext * SUM_W'(GLYPH_H);
  assign row_nl    = sat8(SUM_W'(cursor_row) + step_h);
  assign wrap      = (SUM_W'(cursor_col) + step_w) > SUM_W'(PANEL_WIDTH);
  assign col2      = wrap ? CUR_W'(line_origin) : cursor_col;
  assign row2      = wrap ? row_nl : cursor_row;
  assign bottom    = (SUM_W'(row2) + step_h) > SUM_W'(PANEL_HEIGHT);
  assign col_adv   = sat8(SUM_W'(col2) + step_w);
  assign last_row  = SUM_W'(row2) + glyph_hgt - SUM_W'(1);

  // Vertical magnification of one glyph column, with its coverage mask.
  assign col_bits = glyph_column(glyph_word(glyph_idx), gcol);

  always_comb begin
    exp_next  = '0;
    mask_next = '0;
    for (int sv = 1; sv <= MAX_SCALE; sv++) begin
      if (cell_scale == SCALE_W'(sv)) begin
        for (int r = 0; r < GLYPH_H; r++) begin
          for (int j = 0; j < sv; j++) begin
            exp_next[r*sv+j]  = col_bits[r];
            mask_next[r*sv+j] = 1'b1;
          end
        end
      end
    end
  end

  // Frame byte under the walk, and the glyph rows that fall into it.
  assign x_ok      = x_cur < X_W'(PANEL_WIDTH);
  assign draw_addr = ADDR_W'(page) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(x_cur);
  assign off       = OFF_W'(SUM_W'({page, 3'b000}) + SUM_W'(8) - SUM_W'(draw_y));
  assign ext_bits  = {8'h00, exp_bits, 8'h00};
  assign ext_mask  = {8'h00, exp_mask, 8'h00};
  assign byte_bits = ext_bits[off +: DATA_W];
  assign byte_mask = ext_mask[off +: DATA_W];
  assign last_page = (page == page_last);
  assign last_sub  = (sx == SX_W'(cell_scale - SCALE_W'(1)));
  assign last_col  = (gcol == GCOL_W'(GLYPH_W - 1));

  // Memory port selection: the sweep and the write-back never overlap.
  assign raddr     = (state == S_IDLE) ? ADDR_W'(byte_index) : draw_addr;
  assign mem_we    = (state == S_WIPE) || wr_pend;
  assign mem_waddr = (state == S_WIPE) ? wipe_addr : wr_addr;
  assign mem_wdata = (state == S_WIPE) ? '0 : ((rdata & ~wr_mask) | (wr_bits & wr_mask));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= frame_mem[raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_WIPE;
      wipe_addr      <= '0;
      clr_result     <= 1'b0;
      cursor_col     <= '0;
      cursor_row     <= '0;
      line_origin    <= '0;
      cell_scale     <= SCALE_W'(1);
      string_stopped <= 1'b0;
      wr_pend        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      wr_pend <= (state == S_DRAW) && x_ok;

      case (state)
        S_WIPE: begin
          if (wipe_addr == ADDR_W'(STORE_BYTES - 1)) begin
            wipe_addr <= '0;
            if (clr_result) begin
              res_status <= ST_CLEARED;
              res_data   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            wipe_addr <= wipe_addr + ADDR_W'(1);
          end
        end

        S_IDLE: begin
          if (in_fire) begin
            case (req_type)
              REQ_CLEAR: begin
                clr_result <= 1'b1;
                state      <= S_WIPE;
              end
              REQ_DRAW: begin
                // A new string places the cursor at its origin.
                if (first) begin
                  line_origin    <= origin_x;
                  cursor_col     <= CUR_W'(origin_x);
                  cursor_row     <= CUR_W'(origin_y);
                  cell_scale     <= scale_in;
                  string_stopped <= 1'b0;
                end
                is_nl     <= (char_code == NEWLINE_CODE);
                glyph_idx <= glyph_index(char_code);
                state     <= S_DECIDE;
              end
              default: begin
                rd_ok <= CMP_W'(byte_index) < CMP_W'(STORE_BYTES);
                state <= S_READ;
              end
            endcase
          end
        end

        S_READ: begin
          res_status <= ST_READ;
          res_data   <= rd_ok ? rdata : '0;
          state      <= S_DONE;
        end

        S_DECIDE: begin
          res_data <= '0;
          if (string_stopped) begin
            res_status <= ST_IGNORED;
            state      <= S_DONE;
          end else if (is_nl) begin
            cursor_col <= CUR_W'(line_origin);
            cursor_row <= row_nl;
            res_status <= ST_NEWLINE;
            state      <= S_DONE;
          end else if (bottom) begin
            // The wrap still moves the cursor before the string stops.
            cursor_col     <= col2;
            cursor_row     <= row2;
            string_stopped <= 1'b1;
            res_status     <= ST_IGNORED;
            state          <= S_DONE;
          end else begin
            cursor_col <= col_adv;
            cursor_row <= row2;
            x_cur      <= X_W'(col2);
            draw_y     <= row2;
            page_first <= PAGE_W'(row2 >> 3);
            page_last  <= PAGE_W'(last_row >> 3);
            gcol       <= '0;
            state      <= S_LOAD;
          end
        end

        S_LOAD: begin
          exp_bits <= exp_next;
          exp_mask <= mask_next;
          sx       <= '0;
          page     <= page_first;
          state    <= S_DRAW;
        end

        S_DRAW: begin
          // Read this byte now; it is merged and written back next cycle.
          wr_addr <= draw_addr;
          wr_bits <= byte_bits;
          wr_mask <= byte_mask;
          if (last_page) begin
            page  <= page_first;
            x_cur <= x_cur + X_W'(1);
            if (last_sub) begin
              if (last_col) begin
                res_status <= ST_DRAWN;
                state      <= S_DONE;
              end else begin
                gcol  <= gcol + GCOL_W'(1);
                state <= S_LOAD;
              end
            end else begin
              sx <= sx + SX_W'(1);
            end
          end else begin
            page <= page + PAGE_W'(1);
          end
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // Result register.
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
        status    <= res_status;
        read_data <= res_data;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SGTR_ASSERT(a_wr_after_draw, clk, rst, wr_pend |-> $past(state == S_DRAW), "write-back without a preceding read")
  `SGTR_ASSERT(a_no_rmw_overlap, clk, rst, (wr_pend && state == S_DRAW && x_ok) |-> (wr_addr != draw_addr), "read and write-back hit the same byte")
  `SGTR_ASSERT(a_page_window, clk, rst, (state == S_DRAW) |-> (page >= page_first && page <= page_last), "page walk left the glyph window")
  `SGTR_ASSERT(a_wipe_no_pending, clk, rst, (state == S_WIPE) |-> !wr_pend, "clearing sweep collides with a write-back")
  `SGTR_ASSERT_NEXT(a_done_loads_out, clk, rst, state == S_DONE && out_free, out_valid && state == S_IDLE, "finished result not presented")

endmodule

/* dv/tb_scaled_glyph_text_renderer.sv */
`timescale 1ns / 1ps

module tb_scaled_glyph_text_renderer
  import sgtr_pkg::*;
;

  localparam int PANEL_W     = DEF_PANEL_WIDTH;
  localparam int PANEL_H     = DEF_PANEL_HEIGHT;
  localparam int SCALE_LIMIT = DEF_MAX_SCALE;
  localparam int PAGES       = (PANEL_H + 7) / 8;
  localparam int STORE_BYTES = PANEL_W * PAGES;
  localparam int CURSOR_MAX  = 255;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 40;

  // Read encodings that the package leaves unnamed; both fetch a frame byte.
  localparam logic [REQ_W-1:0] REQ_READ     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ_ALT = 2'd3;

  typedef struct {
    logic [REQ_W-1:0]   kind;
    logic [CODE_W-1:0]  char_code;
    logic               first;
    logic [OX_W-1:0]    origin_x;
    logic [OY_W-1:0]    origin_y;
    logic [SCALE_W-1:0] scale;
    logic [BIDX_W-1:0]  byte_index;
  } render_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
  } frame_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   read_data;
  render_req_t drive_req = '{kind: REQ_READ, char_code: '0, first: 1'b0, origin_x: '0,
                             origin_y: '0, scale: '0, byte_index: '0};

  // Shadow of the panel and the text cursor.
  logic [7:0] panel_bytes [0:STORE_BYTES-1];
  int cur_col;
  int cur_row;
  int line_org;
  int cell_sc;
  bit stopped;

  // 5x7 font, five column bytes per glyph with the leftmost column on top.
  logic [39:0] font_columns [0:95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0804081008, 40'h0000000000
  };

  render_req_t  render_requests [$];
  frame_reply_t frame_replies [$];
  int total_requests;
  int accepted_count = 0;
  int reply_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int tx_gap = 0;
  int rx_hold = 0;
  bit tx_busy = 1'b1;
  bit rx_busy = 1'b1;
  bit final_stretch = 1'b0;

  scaled_glyph_text_renderer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (drive_req.kind),
    .char_code  (drive_req.char_code),
    .first      (drive_req.first),
    .origin_x   (drive_req.origin_x),
    .origin_y   (drive_req.origin_y),
    .scale      (drive_req.scale),
    .byte_index (drive_req.byte_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_data  (read_data)
  );

  // Free-running clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic note_failure(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic int clamp_cursor(input int v);
    return (v > CURSOR_MAX) ? CURSOR_MAX : v;
  endfunction

  // Applies one request to the shadow panel and returns the reply it should give.
  function automatic frame_reply_t apply_render_request(input render_req_t rq);
    frame_reply_t rp;
    int s;
    int x;
    int y;
    logic [CODE_W-1:0] code;
    logic [39:0] shape;
    logic lit;
    rp.status    = ST_DRAWN;
    rp.read_data = '0;
    if (rq.kind == REQ_CLEAR) begin
      foreach (panel_bytes[i]) panel_bytes[i] = '0;
      rp.status = ST_CLEARED;
      return rp;
    end
    // Both remaining encodings are reads.
    if (rq.kind != REQ_DRAW) begin
      rp.status = ST_READ;
      if (rq.byte_index < STORE_BYTES) rp.read_data = panel_bytes[rq.byte_index];
      return rp;
    end
    // A new string latches origin and scale and restarts the cursor.
    if (rq.first) begin
      s = rq.scale;
      if (s == 0) s = 1;
      if (s > SCALE_LIMIT) s = SCALE_LIMIT;
      line_org = rq.origin_x;
      cur_col  = rq.origin_x;
      cur_row  = rq.origin_y;
      cell_sc  = s;
      stopped  = 1'b0;
    end
    if (stopped) begin
      rp.status = ST_IGNORED;
      return rp;
    end
    s = cell_sc;
    if (rq.char_code == NEWLINE_CODE) begin
      cur_col = line_org;
      cur_row = clamp_cursor(cur_row + 8 * s);
      rp.status = ST_NEWLINE;
      return rp;
    end
    // Wrap when the cell would overrun the right edge, then check the bottom.
    if (cur_col + 6 * s > PANEL_W) begin
      cur_col = line_org;
      cur_row = clamp_cursor(cur_row + 8 * s);
    end
    if (cur_row + 8 * s > PANEL_H) begin
      stopped = 1'b1;
      rp.status = ST_IGNORED;
      return rp;
    end
    code = (rq.char_code < FIRST_PRINT || rq.char_code > LAST_PRINT) ? FALLBACK_CODE
                                                                    : rq.char_code;
    shape = font_columns[code - FIRST_PRINT];
    // Opaque, scaled glyph; pixels off the panel are dropped.
    for (int c = 0; c < 5; c++) begin
      for (int r = 0; r < 7; r++) begin
        lit = shape[8 * (4 - c) + r];
        for (int sx = 0; sx < s; sx++) begin
          for (int sy = 0; sy < s; sy++) begin
            x = cur_col + c * s + sx;
            y = cur_row + r * s + sy;
            if (x < PANEL_W && y < PANEL_H) panel_bytes[(y / 8) * PANEL_W + x][y % 8] = lit;
          end
        end
      end
    end
    cur_col = clamp_cursor(cur_col + 6 * s);
    return rp;
  endfunction

  function automatic render_req_t random_request();
    render_req_t rq;
    rq.kind       = REQ_W'($urandom_range(0, 3));
    rq.char_code  = CODE_W'($urandom_range(0, 255));
    rq.first      = 1'($urandom_range(0, 1));
    rq.origin_x   = OX_W'($urandom_range(0, 127));
    rq.origin_y   = OY_W'($urandom_range(0, 63));
    rq.scale      = SCALE_W'($urandom_range(0, 15));
    rq.byte_index = BIDX_W'($urandom_range(0, 1023));
    return rq;
  endfunction

  // Unused fields keep random values so that the block must ignore them.
  task automatic add_draw(input logic [CODE_W-1:0] code, input logic start,
                          input int ox, input int oy, input int sc);
    render_req_t rq;
    rq = random_request();
    rq.kind      = REQ_DRAW;
    rq.char_code = code;
    rq.first     = start;
    if (start) begin
      rq.origin_x = OX_W'(ox);
      rq.origin_y = OY_W'(oy);
      rq.scale    = SCALE_W'(sc);
    end
    render_requests.push_back(rq);
  endtask

  task automatic add_read(input int idx, input logic [REQ_W-1:0] kind);
    render_req_t rq;
    rq = random_request();
    rq.kind       = kind;
    rq.byte_index = BIDX_W'(idx);
    render_requests.push_back(rq);
  endtask

  task automatic add_clear();
    render_req_t rq;
    rq = random_request();
    rq.kind = REQ_CLEAR;
    render_requests.push_back(rq);
  endtask

  // Request driver: pops pending transactions, with random bursts of idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        frame_replies.push_back(apply_render_request(drive_req));
        accepted_count++;
        if ($urandom_range(0, 29) == 0) tx_busy = !tx_busy;
      end
      final_stretch = (render_requests.size() < 50);
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          in_valid <= 1'b0;
          tx_gap--;
        end else if (render_requests.size() == 0) begin
          in_valid <= 1'b0;
        end else if (tx_busy && !final_stretch && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          tx_gap = $urandom_range(0, 8);
        end else begin
          drive_req <= render_requests.pop_front();
          in_valid  <= 1'b1;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_replies.size() == 0) begin
          note_failure($sformatf("result %0d arrived with nothing outstanding (status %0d)",
                                 reply_count, status));
        end else begin
          frame_reply_t want;
          want = frame_replies.pop_front();
          if (status !== want.status)
            note_failure($sformatf("result %0d status: got %0d, want %0d",
                                   reply_count, status, want.status));
          if (read_data !== want.read_data)
            note_failure($sformatf("result %0d read_data: got 0x%02h, want 0x%02h",
                                   reply_count, read_data, want.read_data));
        end
        reply_count++;
        if ($urandom_range(0, 24) == 0) rx_busy = !rx_busy;
      end
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else if (rx_busy && !final_stretch && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        rx_hold = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, frame_replies.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int roll;
    int sc;
    int s_eff;
    int ox;
    int oy;
    int len;
    int page;
    int col;

    foreach (panel_bytes[i]) panel_bytes[i] = '0;
    cur_col  = 0;
    cur_row  = 0;
    line_org = 0;
    cell_sc  = 1;
    stopped  = 1'b0;

    // Directed: empty store, scale zero, unprintable codes and the blank glyph.
    add_read(0, REQ_READ);
    add_draw(8'h41, 1'b1, 0, 0, 0);
    add_draw(8'h00, 1'b0, 0, 0, 0);
    add_draw(8'hFF, 1'b0, 0, 0, 0);
    add_draw(8'h1F, 1'b0, 0, 0, 0);
    add_draw(8'h7F, 1'b0, 0, 0, 0);
    add_draw(8'h20, 1'b0, 0, 0, 0);
    add_draw(NEWLINE_CODE, 1'b0, 0, 0, 0);
    add_read(PANEL_W, REQ_READ);
    // Rightmost origin: wraps at once and the glyph is clipped at the edge.
    add_draw(8'h48, 1'b1, 127, 0, 1);
    add_read(PANEL_W + 127, REQ_READ);
    // Cell that just fits the bottom-right corner, then the string runs off the bottom.
    add_draw(8'h5A, 1'b1, 122, 56, 1);
    add_read(7 * PANEL_W + 122, REQ_READ);
    add_draw(8'h5A, 1'b0, 0, 0, 0);
    add_draw(NEWLINE_CODE, 1'b0, 0, 0, 0);
    // Oversized scale saturates; wrap followed by a stop.
    add_draw(8'h57, 1'b1, 100, 63, 15);
    // Largest scale filling the whole panel height.
    add_draw(8'h4D, 1'b1, 0, 0, 8);
    add_read(3 * PANEL_W + 10, REQ_READ);
    // Newlines carry the cursor row to saturation; the next glyph is dropped.
    add_draw(NEWLINE_CODE, 1'b1, 5, 0, 8);
    add_draw(NEWLINE_CODE, 1'b0, 0, 0, 0);
    add_draw(NEWLINE_CODE, 1'b0, 0, 0, 0);
    add_draw(NEWLINE_CODE, 1'b0, 0, 0, 0);
    add_draw(8'h42, 1'b0, 0, 0, 0);
    add_read(1023, REQ_READ_ALT);
    add_clear();
    add_read(3 * PANEL_W + 10, REQ_READ);

    // Random: mostly whole strings followed by reads of the area just drawn.
    while (render_requests.size() < 420) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        add_clear();
      end else if (roll < 12) begin
        render_requests.push_back(random_request());
      end else begin
        roll = $urandom_range(0, 9);
        if (roll < 7) sc = $urandom_range(0, 3);
        else if (roll < 9) sc = $urandom_range(4, 8);
        else sc = $urandom_range(9, 15);
        s_eff = (sc == 0) ? 1 : (sc > SCALE_LIMIT) ? SCALE_LIMIT : sc;
        ox = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 40);
        oy = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 20);
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          roll = $urandom_range(0, 9);
          if (roll == 0) add_draw(NEWLINE_CODE, k == 0, ox, oy, sc);
          else if (roll == 1) add_draw(CODE_W'($urandom_range(0, 255)), k == 0, ox, oy, sc);
          else add_draw(CODE_W'($urandom_range(32, 127)), k == 0, ox, oy, sc);
        end
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          page = oy / 8 + $urandom_range(0, s_eff);
          if (page >= PAGES) page = PAGES - 1;
          col = ox + $urandom_range(0, 18 * s_eff);
          if (col >= PANEL_W) col = PANEL_W - 1;
          add_read(page * PANEL_W + col, $urandom_range(0, 3) == 0 ? REQ_READ_ALT : REQ_READ);
        end
      end
    end
    total_requests = render_requests.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_requests || frame_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* scaled_glyph_text_renderer.f */
+incdir+hw/rtl
hw/rtl/sgtr_pkg.sv
hw/rtl/scaled_glyph_text_renderer.sv
dv/tb_scaled_glyph_text_renderer.sv
